### rtl/gdr_pkg.sv
`timescale 1ns / 1ps

package gdr_pkg;

  localparam int ETA_W = 11;
  localparam int PHI_W = 10;
  localparam int DIST_W = 20;
  localparam int CMD_W = 2;

  // Width of the sum of the two squares before the limit compare.
  localparam int SQE_W = 2 * ETA_W;
  localparam int SQP_W = 2 * PHI_W;
  localparam int SUM_W = SQE_W + 1;

  localparam int MAX_REFS_DEFAULT = 64;
  localparam logic [DIST_W-1:0] LIMIT_RESET = DIST_W'(4249);

  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_MATCH = 2'd2;

  // Query and best-so-far that travel down the row of cells.
  typedef struct packed {
    logic                    valid;
    logic signed [ETA_W-1:0] eta;
    logic [PHI_W-1:0]        phi;
    logic                    found;
    logic [DIST_W-1:0]       dsq;
  } gdr_token_t;

  // Commands broadcast to every cell; per-cell selects come alongside.
  typedef struct packed {
    logic                    clear;
    logic                    load;
    logic                    take;
    logic signed [ETA_W-1:0] eta;
    logic [PHI_W-1:0]        phi;
  } gdr_ctrl_t;

endpackage

### rtl/gdr_cell.sv
`timescale 1ns / 1ps

module gdr_cell #(
  parameter int IDX_W    = 6,
  parameter int CELL_IDX = 0
) (
  input  logic                      clk,
  input  logic                      rst,
  input  gdr_pkg::gdr_ctrl_t        ctrl,
  input  logic                      load_sel,
  input  logic                      take_sel,
  input  logic [gdr_pkg::DIST_W-1:0] limit,
  input  gdr_pkg::gdr_token_t       tok_in,
  input  logic [IDX_W-1:0]          idx_in,
  output gdr_pkg::gdr_token_t       tok_out,
  output logic [IDX_W-1:0]          idx_out
);
  import gdr_pkg::*;

  // Stored reference.
  logic signed [ETA_W-1:0] ref_eta;
  logic [PHI_W-1:0]        ref_phi;
  logic                    ref_valid;
  logic                    ref_taken;

  // First stage: the two squares.
  gdr_token_t       tok1;
  logic [IDX_W-1:0] idx1;
  logic [SQE_W-1:0] sqe;
  logic [SQP_W-1:0] sqp;

  logic signed [ETA_W:0] de;
  logic [ETA_W-1:0]      ae;
  logic [PHI_W-1:0]      dp;
  logic [PHI_W-1:0]      ap;
  logic [SUM_W-1:0]      sum;
  logic                  hit;

  always_comb begin
    de     = {tok_in.eta[ETA_W-1], tok_in.eta} - {ref_eta[ETA_W-1], ref_eta};
    // The eta gap is at most 2047 in magnitude, so it fits ETA_W bits.
    ae     = de[ETA_W] ? ETA_W'(~de + 1'b1) : de[ETA_W-1:0];
    // The phi difference wraps modulo 1024; its magnitude is at most 512.
    dp     = tok_in.phi - ref_phi;
    ap     = dp[PHI_W-1] ? (~dp + 1'b1) : dp;
  end

  always_comb begin
    sum = {1'b0, sqe} + SUM_W'(sqp);
    hit = tok1.valid && ref_valid && !ref_taken && (sum < SUM_W'(limit)) &&
          (!tok1.found || (sum < SUM_W'(tok1.dsq)));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ref_valid     <= 1'b0;
      ref_taken     <= 1'b0;
      tok1.valid    <= 1'b0;
      tok_out.valid <= 1'b0;
    end else begin
      if (ctrl.clear) begin
        ref_valid <= 1'b0;
        ref_taken <= 1'b0;
      end else if (ctrl.load && load_sel) begin
        ref_valid <= 1'b1;
        ref_taken <= 1'b0;
      end else if (ctrl.take && take_sel) begin
        ref_taken <= 1'b1;
      end
      tok1.valid    <= tok_in.valid;
      tok_out.valid <= tok1.valid;
    end
    if (ctrl.load && load_sel) begin
      ref_eta <= ctrl.eta;
      ref_phi <= ctrl.phi;
    end
    tok1.eta   <= tok_in.eta;
    tok1.phi   <= tok_in.phi;
    tok1.found <= tok_in.found;
    tok1.dsq   <= tok_in.dsq;
    idx1       <= idx_in;
    sqe        <= {{ETA_W{1'b0}}, ae} * {{ETA_W{1'b0}}, ae};
    sqp        <= {{PHI_W{1'b0}}, ap} * {{PHI_W{1'b0}}, ap};
    tok_out.eta <= tok1.eta;
    tok_out.phi <= tok1.phi;
    if (hit) begin
      tok_out.found <= 1'b1;
      tok_out.dsq   <= sum[DIST_W-1:0];
      idx_out       <= IDX_W'(CELL_IDX);
    end else begin
      tok_out.found <= tok1.found;
      tok_out.dsq   <= tok1.dsq;
      idx_out       <= idx1;
    end
  end

endmodule

### rtl/greedy_delta_r_matcher.sv
`timescale 1ns / 1ps

// Channel   Direction  Signals                              Transfer when
// command   in         start, busy, cmd, obj_eta, obj_phi   start high, busy low
// result    out        done, matched, match_index,          done high (one cycle)
//                      distance_sq
// config    in         cfg_we, cfg_wdata                    cfg_we high
//
// Clear and load commands act at the transfer edge and give no result; busy stays low.
// A match command sends the query down a row of MAX_REFS cells; each cell registers
// the squares, then the sum and compare. done is registered after the query leaves the
// last cell, and the next command is taken in the cycle done is shown.
// Reset is synchronous and active high; it empties the store and restores the limit.
// The receiver cannot stall: each result is shown for exactly one cycle.

module greedy_delta_r_matcher #(
  parameter int MAX_REFS = gdr_pkg::MAX_REFS_DEFAULT,
  parameter int IDX_W    = $clog2(MAX_REFS)
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic [gdr_pkg::CMD_W-1:0]        cmd,
  input  logic signed [gdr_pkg::ETA_W-1:0] obj_eta,
  input  logic [gdr_pkg::PHI_W-1:0]        obj_phi,
  input  logic                             cfg_we,
  input  logic [gdr_pkg::DIST_W-1:0]       cfg_wdata,
  output logic                             done,
  output logic                             matched,
  output logic [IDX_W-1:0]                 match_index,
  output logic [gdr_pkg::DIST_W-1:0]       distance_sq
);
  import gdr_pkg::*;

  // The count must be able to hold MAX_REFS itself.
  localparam int CNT_W = $clog2(MAX_REFS + 1);

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

  state_t            state;
  logic [CNT_W-1:0]  ref_count;
  logic [DIST_W-1:0] match_limit_sq;
  gdr_token_t        launch;

  logic              accept;
  gdr_ctrl_t         ctrl;
  logic [MAX_REFS-1:0] load_sel;
  logic [MAX_REFS-1:0] take_sel;

  // Chain links: element 0 is the launch register, the last one leaves the row.
  gdr_token_t       tok_c [0:MAX_REFS];
  logic [IDX_W-1:0] idx_c [0:MAX_REFS];

  gdr_token_t       tok_end;
  logic [IDX_W-1:0] idx_end;

  assign busy    = (state == ST_SCAN);
  assign accept  = start && !busy;
  assign tok_end = tok_c[MAX_REFS];
  assign idx_end = idx_c[MAX_REFS];

  // Clear and load act at the transfer edge. A reference is marked taken at
  // the edge where done is registered for a query that leaves the last cell with a match.
  always_comb begin
    ctrl.clear = accept && (cmd == CMD_CLEAR);
    ctrl.load  = accept && (cmd == CMD_LOAD) && (ref_count < CNT_W'(MAX_REFS));
    ctrl.take  = tok_end.valid && tok_end.found;
    ctrl.eta   = obj_eta;
    ctrl.phi   = obj_phi;
  end

  assign tok_c[0] = launch;
  assign idx_c[0] = '0;

  genvar i;
  generate
    for (i = 0; i < MAX_REFS; i++) begin : g_cell
      assign load_sel[i] = (ref_count == CNT_W'(i));
      assign take_sel[i] = (idx_end == IDX_W'(i));

      gdr_cell #(
        .IDX_W    (IDX_W),
        .CELL_IDX (i)
      ) u_cell (
        .clk      (clk),
        .rst      (rst),
        .ctrl     (ctrl),
        .load_sel (load_sel[i]),
        .take_sel (take_sel[i]),
        .limit    (match_limit_sq),
        .tok_in   (tok_c[i]),
        .idx_in   (idx_c[i]),
        .tok_out  (tok_c[i+1]),
        .idx_out  (idx_c[i+1])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      ref_count      <= '0;
      match_limit_sq <= LIMIT_RESET;
      launch.valid   <= 1'b0;
      done           <= 1'b0;
    end else begin
      if (cfg_we) begin
        match_limit_sq <= cfg_wdata;
      end
      launch.valid <= 1'b0;
      done         <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (ctrl.clear) begin
            ref_count <= '0;
          end else if (ctrl.load) begin
            ref_count <= ref_count + 1'b1;
          end else if (accept && (cmd == CMD_MATCH)) begin
            launch.valid <= 1'b1;
            state        <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (tok_end.valid) begin
            done  <= 1'b1;
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
    // The query enters with no match; an unmatched result reads as all zero.
    launch.eta   <= obj_eta;
    launch.phi   <= obj_phi;
    launch.found <= 1'b0;
    launch.dsq   <= '0;
    matched      <= tok_end.found;
    match_index  <= idx_end;
    distance_sq  <= tok_end.dsq;
  end

endmodule
